[rtl/core/cbc_pkg.sv]
`default_nettype none
package cbc_pkg;

	localparam int NUM_SLOTS_DEF = 2;
	localparam int CFG_IDX_W = 1;

	localparam logic [31:0] WINDOW_RST = 32'd300000;
	localparam logic [7:0] THRESH_RST = 8'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 1'd1;

	localparam logic [1:0] ST_CLOSED = 2'd0;
	localparam logic [1:0] ST_OPEN = 2'd1;
	localparam logic [1:0] ST_HALF = 2'd2;

	localparam logic [1:0] MODE_ADMIT = 2'd0;
	localparam logic [1:0] MODE_SUCCESS = 2'd1;
	localparam logic [1:0] MODE_FAILURE = 2'd2;
	localparam logic [1:0] MODE_RESTART = 2'd3;

	localparam logic [1:0] KIND_IGNORED = 2'd0;
	localparam logic [1:0] KIND_RETRY = 2'd1;
	localparam logic [1:0] KIND_AUTH = 2'd2;

	localparam logic [3:0] RSN_NONE = 4'd0;
	localparam logic [3:0] RSN_COOLDOWN = 4'd1;
	localparam logic [3:0] RSN_PROBE_OK = 4'd2;
	localparam logic [3:0] RSN_ABANDON = 4'd3;
	localparam logic [3:0] RSN_RST_PROBE = 4'd4;
	localparam logic [3:0] RSN_RESTART = 4'd5;
	localparam logic [3:0] RSN_CFG_FAIL = 4'd6;
	localparam logic [3:0] RSN_FAIL_OPEN = 4'd7;
	localparam logic [3:0] RSN_THRESHOLD = 4'd8;

	localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;

	typedef struct packed {
		logic [1:0] state;
		logic [7:0] fail_count;
		logic [47:0] first_fail_time;
		logic first_fail_valid;
		logic [47:0] retry_time;
		logic retry_valid;
		logic [47:0] opened_time;
		logic indefinite_open;
		logic probe_busy;
		logic [31:0] rev_count;
	} entry_t;

	typedef struct packed {
		logic admitted;
		logic [1:0] state_after;
		logic transitioned;
		logic [3:0] transition_reason;
		logic [31:0] revision;
		logic [7:0] failure_count;
	} result_t;

endpackage
`default_nettype wire

[rtl/core/cbc_eval.sv]
`default_nettype none
module cbc_eval (
	input wire cbc_pkg::entry_t cur,
	input wire logic [1:0] mode,
	input wire logic [1:0] failure_kind,
	input wire logic [47:0] now_ms,
	input wire logic [31:0] window_ms,
	input wire logic [7:0] open_threshold,
	output cbc_pkg::entry_t nxt,
	output cbc_pkg::result_t res
);

	logic auth;
	logic fresh;
	logic [7:0] cnt;
	logic [47:0] first;
	logic open_it;
	logic [48:0] retry_sum;
	logic [47:0] retry_at;
	logic [47:0] elapsed;
	logic [47:0] release_time;
	logic admitted;
	logic [3:0] reason;
	logic is_closed;
	logic is_half;

	assign is_closed = (cur.state == cbc_pkg::ST_CLOSED);
	assign is_half = (cur.state == cbc_pkg::ST_HALF);
	assign auth = (failure_kind == cbc_pkg::KIND_AUTH);
	assign elapsed = now_ms - cur.first_fail_time;
	assign fresh = !cur.first_fail_valid ||
		((now_ms >= cur.first_fail_time) && (elapsed > {16'd0, window_ms}));
	assign cnt = fresh ? 8'd1 : ((cur.fail_count == 8'hFF) ? 8'hFF : cur.fail_count + 8'd1);
	assign first = fresh ? now_ms : cur.first_fail_time;
	assign open_it = auth || is_half || (cnt >= open_threshold);
	assign retry_sum = {1'b0, now_ms} + {17'd0, window_ms};
	assign retry_at = retry_sum[48] ? cbc_pkg::TIME_MAX : retry_sum[47:0];
	assign release_time = (cur.opened_time > now_ms) ? cur.opened_time : now_ms;

	always_comb begin
		nxt = cur;
		admitted = 1'b0;
		reason = cbc_pkg::RSN_NONE;
		case (mode)
			cbc_pkg::MODE_ADMIT: begin
				if (is_closed) begin
					admitted = 1'b1;
				end else if (!(is_half || cur.indefinite_open || !cur.retry_valid ||
					(now_ms < cur.retry_time))) begin
					nxt.state = cbc_pkg::ST_HALF;
					nxt.probe_busy = 1'b1;
					nxt.rev_count = cur.rev_count + 32'd1;
					reason = cbc_pkg::RSN_COOLDOWN;
					admitted = 1'b1;
				end
			end
			cbc_pkg::MODE_SUCCESS: begin
				if (is_half) begin
					nxt = '0;
					nxt.state = cbc_pkg::ST_CLOSED;
					nxt.rev_count = cur.rev_count + 32'd1;
					reason = cbc_pkg::RSN_PROBE_OK;
				end else if (is_closed) begin
					nxt.fail_count = 8'd0;
					nxt.first_fail_time = 48'd0;
					nxt.first_fail_valid = 1'b0;
				end
			end
			cbc_pkg::MODE_FAILURE: begin
				if (failure_kind == cbc_pkg::KIND_IGNORED) begin
					if (is_half) begin
						nxt.state = cbc_pkg::ST_OPEN;
						nxt.retry_time = release_time;
						nxt.retry_valid = 1'b1;
						nxt.indefinite_open = 1'b0;
						nxt.probe_busy = 1'b0;
						nxt.rev_count = cur.rev_count + 32'd1;
						reason = cbc_pkg::RSN_ABANDON;
					end
				end else if (failure_kind == cbc_pkg::KIND_RETRY || auth) begin
					if (!open_it) begin
						if (is_closed) begin
							nxt.fail_count = cnt;
							nxt.first_fail_time = first;
							nxt.first_fail_valid = 1'b1;
						end
					end else if (!is_closed && !is_half) begin
						if (!cur.indefinite_open) begin
							nxt.fail_count = cnt;
							nxt.first_fail_time = first;
							nxt.first_fail_valid = 1'b1;
							nxt.indefinite_open = auth;
							nxt.retry_valid = !auth;
							nxt.retry_time = auth ? 48'd0 : retry_at;
							nxt.rev_count = cur.rev_count + 32'd1;
							reason = auth ? cbc_pkg::RSN_CFG_FAIL : cbc_pkg::RSN_FAIL_OPEN;
						end
					end else begin
						nxt.state = cbc_pkg::ST_OPEN;
						nxt.fail_count = cnt;
						nxt.first_fail_time = first;
						nxt.first_fail_valid = 1'b1;
						nxt.opened_time = now_ms;
						nxt.retry_valid = !auth;
						nxt.retry_time = auth ? 48'd0 : retry_at;
						nxt.indefinite_open = auth;
						nxt.probe_busy = 1'b0;
						nxt.rev_count = cur.rev_count + 32'd1;
						reason = auth ? cbc_pkg::RSN_CFG_FAIL : cbc_pkg::RSN_THRESHOLD;
					end
				end
			end
			default: begin
				if (is_half) begin
					nxt.state = cbc_pkg::ST_OPEN;
					nxt.retry_time = release_time;
					nxt.retry_valid = 1'b1;
					nxt.indefinite_open = 1'b0;
					nxt.probe_busy = 1'b0;
					nxt.rev_count = cur.rev_count + 32'd1;
					reason = cbc_pkg::RSN_RST_PROBE;
				end else if ((cur.state == cbc_pkg::ST_OPEN) && cur.indefinite_open) begin
					nxt = '0;
					nxt.state = cbc_pkg::ST_CLOSED;
					nxt.rev_count = cur.rev_count + 32'd1;
					reason = cbc_pkg::RSN_RESTART;
				end
			end
		endcase
	end

	always_comb begin
		res.admitted = admitted;
		res.state_after = nxt.state;
		res.transitioned = (nxt.rev_count != cur.rev_count);
		res.transition_reason = reason;
		res.revision = nxt.rev_count;
		res.failure_count = nxt.fail_count;
	end

endmodule
`default_nettype wire

[rtl/core/circuit_breaker_controller_unit.sv]
`default_nettype none
// One circuit breaker per provider slot, one event per request. A request is
// taken when start is high and busy is low; busy then stays high for one cycle
// while the slot entry read from the state memory is evaluated and written
// back, and the result appears on the following cycle for exactly one cycle,
// marked by done, which the receiver cannot stall. A new request may be
// started in the cycle that shows the previous result, so each request waits
// for the read of the state memory and the evaluate and write-back step of
// the previous one. After reset every slot is closed with zero counts and
// revision, window_ms is 300000 and open_threshold is 3; configuration writes
// are always ready.
module circuit_breaker_controller_unit #(
	parameter int NUM_SLOTS = cbc_pkg::NUM_SLOTS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic [1:0] mode,
	input wire logic slot,
	input wire logic [1:0] failure_kind,
	input wire logic [47:0] now_ms,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [cbc_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [31:0] cfg_data,
	output logic done,
	output logic admitted,
	output logic [1:0] state_after,
	output logic transitioned,
	output logic [3:0] transition_reason,
	output logic [31:0] revision,
	output logic [7:0] failure_count
);

	localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

	cbc_pkg::entry_t mem [NUM_SLOTS];
	logic [NUM_SLOTS-1:0] valid_q;

	logic [31:0] window_q;
	logic [7:0] thresh_q;

	logic accept;
	logic in_range;
	logic [AW-1:0] addr;

	logic valid_s1;
	logic in_range_s1;
	logic [AW-1:0] addr_s1;
	logic [1:0] mode_s1;
	logic [1:0] kind_s1;
	logic [47:0] now_s1;
	cbc_pkg::entry_t rd_s1;
	logic rd_vld_s1;

	cbc_pkg::entry_t cur;
	cbc_pkg::entry_t nxt;
	cbc_pkg::result_t res;

	logic done_q;
	cbc_pkg::result_t res_q;

	assign busy = valid_s1;
	assign cfg_ready = 1'b1;
	assign accept = start && !busy;
	assign addr = AW'(slot);
	assign in_range = (32'(slot) < NUM_SLOTS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= cbc_pkg::WINDOW_RST;
			thresh_q <= cbc_pkg::THRESH_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				cbc_pkg::CFG_WINDOW: window_q <= cfg_data;
				cbc_pkg::CFG_THRESH: thresh_q <= cfg_data[7:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			rd_vld_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				rd_vld_s1 <= in_range && valid_q[addr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			in_range_s1 <= in_range;
			addr_s1 <= addr;
			mode_s1 <= mode;
			kind_s1 <= failure_kind;
			now_s1 <= now_ms;
			rd_s1 <= mem[addr];
		end
		if (valid_s1 && in_range_s1) begin
			mem[addr_s1] <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (valid_s1 && in_range_s1) begin
			valid_q[addr_s1] <= 1'b1;
		end
	end

	assign cur = rd_vld_s1 ? rd_s1 : '0;

	cbc_eval u_eval (
		.cur(cur),
		.mode(mode_s1),
		.failure_kind(kind_s1),
		.now_ms(now_s1),
		.window_ms(window_q),
		.open_threshold(thresh_q),
		.nxt(nxt),
		.res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			res_q <= in_range_s1 ? res : '0;
		end
	end

	assign done = done_q;
	assign admitted = res_q.admitted;
	assign state_after = res_q.state_after;
	assign transitioned = res_q.transitioned;
	assign transition_reason = res_q.transition_reason;
	assign revision = res_q.revision;
	assign failure_count = res_q.failure_count;

`ifndef ASSERT_OFF
	a_eval_then_done: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> done)
		else $error("evaluated request produced no result");

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while a request is still being evaluated");

	a_reason_matches: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (transitioned == (transition_reason != cbc_pkg::RSN_NONE)))
		else $error("transition flag disagrees with transition reason");
`endif

endmodule
`default_nettype wire

[verif/circuit_breaker_controller_unit_tb.sv]
`default_nettype none
module circuit_breaker_controller_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int PHASES = 8;
	localparam int ITEMS_PER_PHASE = 225;

	typedef struct packed {
		logic known;
		logic [1:0] md;
		logic sl;
		logic [1:0] fk;
		logic [47:0] tn;
		cbc_pkg::result_t res;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	logic [1:0] mode;
	logic slot;
	logic [1:0] failure_kind;
	logic [47:0] now_ms;
	logic cfg_valid;
	logic cfg_ready;
	logic [cbc_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [31:0] cfg_data;
	logic done;
	logic admitted;
	logic [1:0] state_after;
	logic transitioned;
	logic [3:0] transition_reason;
	logic [31:0] revision;
	logic [7:0] failure_count;

	// Local copy of the configuration and of every breaker.
	logic [31:0] cur_window;
	logic [7:0] cur_thresh;
	logic [1:0] brk_state [2];
	logic [7:0] brk_fails [2];
	logic [47:0] brk_first_t [2];
	logic brk_first_ok [2];
	logic [47:0] brk_retry_t [2];
	logic brk_retry_ok [2];
	logic [47:0] brk_open_t [2];
	logic brk_hold [2];
	logic brk_probe [2];
	logic [31:0] brk_rev [2];

	cbc_pkg::result_t breaker_results_due [$];
	dir_row_t dir_tab [$];
	int err_cnt = 0;
	int idle_pct = 0;
	int stall_cycles = 0;

	circuit_breaker_controller_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mode(mode),
		.slot(slot),
		.failure_kind(failure_kind),
		.now_ms(now_ms),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.done(done),
		.admitted(admitted),
		.state_after(state_after),
		.transitioned(transitioned),
		.transition_reason(transition_reason),
		.revision(revision),
		.failure_count(failure_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void close_breaker(int s);
		brk_state[s] = cbc_pkg::ST_CLOSED;
		brk_fails[s] = 8'd0;
		brk_first_t[s] = 48'd0;
		brk_first_ok[s] = 1'b0;
		brk_open_t[s] = 48'd0;
		brk_retry_t[s] = 48'd0;
		brk_retry_ok[s] = 1'b0;
		brk_hold[s] = 1'b0;
		brk_probe[s] = 1'b0;
		brk_rev[s] = brk_rev[s] + 32'd1;
	endfunction

	function automatic void release_breaker(int s, logic [47:0] tn);
		brk_state[s] = cbc_pkg::ST_OPEN;
		brk_retry_t[s] = (brk_open_t[s] > tn) ? brk_open_t[s] : tn;
		brk_retry_ok[s] = 1'b1;
		brk_hold[s] = 1'b0;
		brk_probe[s] = 1'b0;
		brk_rev[s] = brk_rev[s] + 32'd1;
	endfunction

	function automatic logic [47:0] retry_deadline(logic [47:0] tn);
		logic [63:0] t;
		t = {16'd0, tn} + {32'd0, cur_window};
		return (t > {16'd0, cbc_pkg::TIME_MAX}) ? cbc_pkg::TIME_MAX : t[47:0];
	endfunction

	function automatic cbc_pkg::result_t breaker_event(logic [1:0] md, logic sl,
			logic [1:0] fk, logic [47:0] tn);
		cbc_pkg::result_t r;
		int s;
		logic [31:0] rev_prev;
		logic [3:0] why;
		logic adm;
		logic fresh;
		logic auth;
		logic open_it;
		logic [7:0] cnt;
		logic [47:0] first;
		s = sl;
		rev_prev = brk_rev[s];
		why = cbc_pkg::RSN_NONE;
		adm = 1'b0;
		case (md)
			cbc_pkg::MODE_ADMIT: begin
				if (brk_state[s] == cbc_pkg::ST_CLOSED) begin
					adm = 1'b1;
				end else if (brk_state[s] == cbc_pkg::ST_HALF || brk_hold[s] ||
						!brk_retry_ok[s] || tn < brk_retry_t[s]) begin
					adm = 1'b0;
				end else begin
					brk_state[s] = cbc_pkg::ST_HALF;
					brk_probe[s] = 1'b1;
					brk_rev[s] = brk_rev[s] + 32'd1;
					why = cbc_pkg::RSN_COOLDOWN;
					adm = 1'b1;
				end
			end
			cbc_pkg::MODE_SUCCESS: begin
				if (brk_state[s] == cbc_pkg::ST_HALF) begin
					close_breaker(s);
					why = cbc_pkg::RSN_PROBE_OK;
				end else if (brk_state[s] == cbc_pkg::ST_CLOSED) begin
					brk_fails[s] = 8'd0;
					brk_first_t[s] = 48'd0;
					brk_first_ok[s] = 1'b0;
				end
			end
			cbc_pkg::MODE_FAILURE: begin
				if (fk == cbc_pkg::KIND_IGNORED) begin
					if (brk_state[s] == cbc_pkg::ST_HALF) begin
						release_breaker(s, tn);
						why = cbc_pkg::RSN_ABANDON;
					end
				end else if (fk == cbc_pkg::KIND_RETRY || fk == cbc_pkg::KIND_AUTH) begin
					auth = (fk == cbc_pkg::KIND_AUTH);
					fresh = !brk_first_ok[s] || (tn >= brk_first_t[s] &&
						(tn - brk_first_t[s]) > {16'd0, cur_window});
					cnt = fresh ? 8'd1 :
						((brk_fails[s] == 8'd255) ? 8'd255 : brk_fails[s] + 8'd1);
					first = fresh ? tn : brk_first_t[s];
					open_it = auth || brk_state[s] == cbc_pkg::ST_HALF || cnt >= cur_thresh;
					if (!open_it) begin
						if (brk_state[s] == cbc_pkg::ST_CLOSED) begin
							brk_fails[s] = cnt;
							brk_first_t[s] = first;
							brk_first_ok[s] = 1'b1;
						end
					end else if (brk_state[s] != cbc_pkg::ST_CLOSED &&
							brk_state[s] != cbc_pkg::ST_HALF) begin
						if (!brk_hold[s]) begin
							brk_fails[s] = cnt;
							brk_first_t[s] = first;
							brk_first_ok[s] = 1'b1;
							brk_hold[s] = auth;
							brk_retry_ok[s] = !auth;
							brk_retry_t[s] = auth ? 48'd0 : retry_deadline(tn);
							brk_rev[s] = brk_rev[s] + 32'd1;
							why = auth ? cbc_pkg::RSN_CFG_FAIL : cbc_pkg::RSN_FAIL_OPEN;
						end
					end else begin
						brk_state[s] = cbc_pkg::ST_OPEN;
						brk_fails[s] = cnt;
						brk_first_t[s] = first;
						brk_first_ok[s] = 1'b1;
						brk_open_t[s] = tn;
						brk_retry_ok[s] = !auth;
						brk_retry_t[s] = auth ? 48'd0 : retry_deadline(tn);
						brk_hold[s] = auth;
						brk_probe[s] = 1'b0;
						brk_rev[s] = brk_rev[s] + 32'd1;
						why = auth ? cbc_pkg::RSN_CFG_FAIL : cbc_pkg::RSN_THRESHOLD;
					end
				end
			end
			default: begin
				if (brk_state[s] == cbc_pkg::ST_HALF) begin
					release_breaker(s, tn);
					why = cbc_pkg::RSN_RST_PROBE;
				end else if (brk_state[s] == cbc_pkg::ST_OPEN && brk_hold[s]) begin
					close_breaker(s);
					why = cbc_pkg::RSN_RESTART;
				end
			end
		endcase
		r.admitted = adm;
		r.state_after = brk_state[s];
		r.transitioned = (brk_rev[s] != rev_prev);
		r.transition_reason = why;
		r.revision = brk_rev[s];
		r.failure_count = brk_fails[s];
		return r;
	endfunction

	function automatic dir_row_t dr(logic known, logic [1:0] md, logic sl, logic [1:0] fk,
			logic [47:0] tn, logic adm, logic [1:0] st, logic tr, logic [3:0] rsn,
			logic [31:0] rev, logic [7:0] fc);
		dir_row_t d;
		d.known = known;
		d.md = md;
		d.sl = sl;
		d.fk = fk;
		d.tn = tn;
		d.res.admitted = adm;
		d.res.state_after = st;
		d.res.transitioned = tr;
		d.res.transition_reason = rsn;
		d.res.revision = rev;
		d.res.failure_count = fc;
		return d;
	endfunction

	function automatic logic [47:0] next_time(logic [47:0] t);
		logic [63:0] v;
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 55) begin
			v = {16'd0, t} + $urandom_range(3);
		end else if (pick < 80) begin
			v = {16'd0, t} + {32'd0, cur_window} + $urandom_range(4);
			if (v >= 64'd2) v = v - 64'd2;
		end else if (pick < 88) begin
			v = {16'd0, t};
			pick = $urandom_range(1000);
			v = (v > pick) ? v - pick : 64'd0;
		end else if (pick < 94) begin
			v = {$urandom, $urandom} & {16'd0, cbc_pkg::TIME_MAX};
		end else begin
			v = {16'd0, cbc_pkg::TIME_MAX} - $urandom_range(3);
		end
		return (v > {16'd0, cbc_pkg::TIME_MAX}) ? cbc_pkg::TIME_MAX : v[47:0];
	endfunction

	task automatic send_event(logic [1:0] md, logic sl, logic [1:0] fk, logic [47:0] tn,
			logic known, cbc_pkg::result_t typed);
		cbc_pkg::result_t pred;
		while ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			start <= 1'b0;
		end
		@(negedge clk);
		start <= 1'b1;
		mode <= md;
		slot <= sl;
		failure_kind <= fk;
		now_ms <= tn;
		@(posedge clk);
		while (busy) @(posedge clk);
		pred = breaker_event(md, sl, fk, tn);
		breaker_results_due.push_back(known ? typed : pred);
	endtask

	task automatic write_reg(logic [cbc_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == cbc_pkg::CFG_WINDOW)
			cur_window = val;
		else
			cur_thresh = val[7:0];
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (breaker_results_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	always @(posedge clk) begin
		cbc_pkg::result_t want;
		if (arst_n && done) begin
			if (breaker_results_due.size() == 0) begin
				$error("result with no request outstanding");
				err_cnt++;
			end else begin
				want = breaker_results_due.pop_front();
				if (admitted !== want.admitted) begin
					$error("admitted: expected %0d, got %0d", want.admitted, admitted);
					err_cnt++;
				end
				if (state_after !== want.state_after) begin
					$error("state_after: expected %0d, got %0d", want.state_after, state_after);
					err_cnt++;
				end
				if (transitioned !== want.transitioned) begin
					$error("transitioned: expected %0d, got %0d", want.transitioned,
						transitioned);
					err_cnt++;
				end
				if (transition_reason !== want.transition_reason) begin
					$error("transition_reason: expected %0d, got %0d",
						want.transition_reason, transition_reason);
					err_cnt++;
				end
				if (revision !== want.revision) begin
					$error("revision: expected %0d, got %0d", want.revision, revision);
					err_cnt++;
				end
				if (failure_count !== want.failure_count) begin
					$error("failure_count: expected %0d, got %0d", want.failure_count,
						failure_count);
					err_cnt++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles + 1 >= WATCHDOG_LIMIT) begin
			$display("circuit_breaker_controller_unit_tb: done, errors");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		logic [31:0] win_list [PHASES];
		logic [7:0] thr_list [PHASES];
		int pct_list [PHASES];
		logic [47:0] tnow;
		logic [1:0] md;
		logic [1:0] fk;
		int unsigned pick;
		cbc_pkg::result_t none;

		arst_n = 1'b0;
		start = 1'b0;
		mode = cbc_pkg::MODE_ADMIT;
		slot = 1'b0;
		failure_kind = cbc_pkg::KIND_IGNORED;
		now_ms = 48'd0;
		cfg_valid = 1'b0;
		cfg_index = cbc_pkg::CFG_WINDOW;
		cfg_data = 32'd0;
		none = '0;

		cur_window = cbc_pkg::WINDOW_RST;
		cur_thresh = cbc_pkg::THRESH_RST;
		for (int s = 0; s < 2; s++) begin
			brk_state[s] = cbc_pkg::ST_CLOSED;
			brk_fails[s] = 8'd0;
			brk_first_t[s] = 48'd0;
			brk_first_ok[s] = 1'b0;
			brk_retry_t[s] = 48'd0;
			brk_retry_ok[s] = 1'b0;
			brk_open_t[s] = 48'd0;
			brk_hold[s] = 1'b0;
			brk_probe[s] = 1'b0;
			brk_rev[s] = 32'd0;
		end

		win_list = '{32'd300000, 32'd1, 32'hFFFF_FFFF, 32'd50, 32'd20, 32'd5000,
			32'hFFFF_FFFF, 32'd100};
		thr_list = '{8'd3, 8'd1, 8'd255, 8'd2, 8'd0, 8'd5, 8'd1, 8'd255};
		pct_list = '{0, 81, 25, 81, 0, 25, 81, 0};

		// Walk one breaker through its whole cycle, then the held-open and
		// out-of-order and near-maximum time cases on the other one.
		dir_tab.push_back(dr(1'b1, cbc_pkg::MODE_ADMIT, 1'b0, cbc_pkg::KIND_IGNORED, 48'd0,
			1'b1, cbc_pkg::ST_CLOSED, 1'b0, cbc_pkg::RSN_NONE, 32'd0, 8'd0));
		dir_tab.push_back(dr(1'b1, cbc_pkg::MODE_SUCCESS, 1'b0, cbc_pkg::KIND_IGNORED, 48'd0,
			1'b0, cbc_pkg::ST_CLOSED, 1'b0, cbc_pkg::RSN_NONE, 32'd0, 8'd0));
		dir_tab.push_back(dr(1'b1, cbc_pkg::MODE_FAILURE, 1'b0, cbc_pkg::KIND_RETRY, 48'd1000,
			1'b0, cbc_pkg::ST_CLOSED, 1'b0, cbc_pkg::RSN_NONE, 32'd0, 8'd1));
		dir_tab.push_back(dr(1'b1, cbc_pkg::MODE_FAILURE, 1'b0, cbc_pkg::KIND_RETRY, 48'd2000,
			1'b0, cbc_pkg::ST_CLOSED, 1'b0, cbc_pkg::RSN_NONE, 32'd0, 8'd2));
		dir_tab.push_back(dr(1'b1, cbc_pkg::MODE_FAILURE, 1'b0, cbc_pkg::KIND_IGNORED,
			48'd2500, 1'b0, cbc_pkg::ST_CLOSED, 1'b0, cbc_pkg::RSN_NONE, 32'd0, 8'd2));
		dir_tab.push_back(dr(1'b1, cbc_pkg::MODE_FAILURE, 1'b0, 2'd3, 48'd2600,
			1'b0, cbc_pkg::ST_CLOSED, 1'b0, cbc_pkg::RSN_NONE, 32'd0, 8'd2));
		dir_tab.push_back(dr(1'b1, cbc_pkg::MODE_FAILURE, 1'b0, cbc_pkg::KIND_RETRY, 48'd3000,
			1'b0, cbc_pkg::ST_OPEN, 1'b1, cbc_pkg::RSN_THRESHOLD, 32'd1, 8'd3));
		dir_tab.push_back(dr(1'b1, cbc_pkg::MODE_ADMIT, 1'b0, cbc_pkg::KIND_IGNORED, 48'd3001,
			1'b0, cbc_pkg::ST_OPEN, 1'b0, cbc_pkg::RSN_NONE, 32'd1, 8'd3));
		dir_tab.push_back(dr(1'b1, cbc_pkg::MODE_SUCCESS, 1'b0, cbc_pkg::KIND_IGNORED,
			48'd3002, 1'b0, cbc_pkg::ST_OPEN, 1'b0, cbc_pkg::RSN_NONE, 32'd1, 8'd3));
		dir_tab.push_back(dr(1'b1, cbc_pkg::MODE_FAILURE, 1'b0, cbc_pkg::KIND_RETRY, 48'd4000,
			1'b0, cbc_pkg::ST_OPEN, 1'b1, cbc_pkg::RSN_FAIL_OPEN, 32'd2, 8'd4));
		dir_tab.push_back(dr(1'b1, cbc_pkg::MODE_ADMIT, 1'b0, cbc_pkg::KIND_IGNORED,
			48'd304000, 1'b1, cbc_pkg::ST_HALF, 1'b1, cbc_pkg::RSN_COOLDOWN, 32'd3, 8'd4));
		dir_tab.push_back(dr(1'b1, cbc_pkg::MODE_ADMIT, 1'b0, cbc_pkg::KIND_IGNORED,
			48'd304001, 1'b0, cbc_pkg::ST_HALF, 1'b0, cbc_pkg::RSN_NONE, 32'd3, 8'd4));
		dir_tab.push_back(dr(1'b1, cbc_pkg::MODE_FAILURE, 1'b0, cbc_pkg::KIND_IGNORED,
			48'd304002, 1'b0, cbc_pkg::ST_OPEN, 1'b1, cbc_pkg::RSN_ABANDON, 32'd4, 8'd4));
		dir_tab.push_back(dr(1'b1, cbc_pkg::MODE_ADMIT, 1'b0, cbc_pkg::KIND_IGNORED,
			48'd304002, 1'b1, cbc_pkg::ST_HALF, 1'b1, cbc_pkg::RSN_COOLDOWN, 32'd5, 8'd4));
		dir_tab.push_back(dr(1'b1, cbc_pkg::MODE_RESTART, 1'b0, cbc_pkg::KIND_IGNORED,
			48'd304010, 1'b0, cbc_pkg::ST_OPEN, 1'b1, cbc_pkg::RSN_RST_PROBE, 32'd6, 8'd4));
		dir_tab.push_back(dr(1'b1, cbc_pkg::MODE_ADMIT, 1'b0, cbc_pkg::KIND_IGNORED,
			48'd304010, 1'b1, cbc_pkg::ST_HALF, 1'b1, cbc_pkg::RSN_COOLDOWN, 32'd7, 8'd4));
		dir_tab.push_back(dr(1'b1, cbc_pkg::MODE_SUCCESS, 1'b0, cbc_pkg::KIND_IGNORED,
			48'd304011, 1'b0, cbc_pkg::ST_CLOSED, 1'b1, cbc_pkg::RSN_PROBE_OK, 32'd8, 8'd0));
		dir_tab.push_back(dr(1'b1, cbc_pkg::MODE_FAILURE, 1'b1, cbc_pkg::KIND_AUTH, 48'd0,
			1'b0, cbc_pkg::ST_OPEN, 1'b1, cbc_pkg::RSN_CFG_FAIL, 32'd1, 8'd1));
		dir_tab.push_back(dr(1'b1, cbc_pkg::MODE_ADMIT, 1'b1, cbc_pkg::KIND_IGNORED,
			cbc_pkg::TIME_MAX, 1'b0, cbc_pkg::ST_OPEN, 1'b0, cbc_pkg::RSN_NONE, 32'd1, 8'd1));
		dir_tab.push_back(dr(1'b1, cbc_pkg::MODE_FAILURE, 1'b1, cbc_pkg::KIND_RETRY, 48'd10,
			1'b0, cbc_pkg::ST_OPEN, 1'b0, cbc_pkg::RSN_NONE, 32'd1, 8'd1));
		dir_tab.push_back(dr(1'b1, cbc_pkg::MODE_FAILURE, 1'b1, cbc_pkg::KIND_AUTH, 48'd20,
			1'b0, cbc_pkg::ST_OPEN, 1'b0, cbc_pkg::RSN_NONE, 32'd1, 8'd1));
		dir_tab.push_back(dr(1'b1, cbc_pkg::MODE_RESTART, 1'b1, cbc_pkg::KIND_IGNORED, 48'd30,
			1'b0, cbc_pkg::ST_CLOSED, 1'b1, cbc_pkg::RSN_RESTART, 32'd2, 8'd0));
		dir_tab.push_back(dr(1'b1, cbc_pkg::MODE_RESTART, 1'b1, cbc_pkg::KIND_IGNORED, 48'd40,
			1'b0, cbc_pkg::ST_CLOSED, 1'b0, cbc_pkg::RSN_NONE, 32'd2, 8'd0));
		dir_tab.push_back(dr(1'b1, cbc_pkg::MODE_FAILURE, 1'b1, cbc_pkg::KIND_RETRY, 48'd5000,
			1'b0, cbc_pkg::ST_CLOSED, 1'b0, cbc_pkg::RSN_NONE, 32'd2, 8'd1));
		dir_tab.push_back(dr(1'b1, cbc_pkg::MODE_FAILURE, 1'b1, cbc_pkg::KIND_RETRY, 48'd100,
			1'b0, cbc_pkg::ST_CLOSED, 1'b0, cbc_pkg::RSN_NONE, 32'd2, 8'd2));
		dir_tab.push_back(dr(1'b0, cbc_pkg::MODE_FAILURE, 1'b1, cbc_pkg::KIND_RETRY,
			cbc_pkg::TIME_MAX - 48'd10, 1'b0, 2'd0, 1'b0, 4'd0, 32'd0, 8'd0));
		dir_tab.push_back(dr(1'b0, cbc_pkg::MODE_FAILURE, 1'b1, cbc_pkg::KIND_RETRY,
			cbc_pkg::TIME_MAX - 48'd9, 1'b0, 2'd0, 1'b0, 4'd0, 32'd0, 8'd0));
		dir_tab.push_back(dr(1'b0, cbc_pkg::MODE_FAILURE, 1'b1, cbc_pkg::KIND_RETRY,
			cbc_pkg::TIME_MAX - 48'd8, 1'b0, 2'd0, 1'b0, 4'd0, 32'd0, 8'd0));
		dir_tab.push_back(dr(1'b0, cbc_pkg::MODE_ADMIT, 1'b1, cbc_pkg::KIND_IGNORED,
			cbc_pkg::TIME_MAX, 1'b0, 2'd0, 1'b0, 4'd0, 32'd0, 8'd0));
		dir_tab.push_back(dr(1'b0, cbc_pkg::MODE_FAILURE, 1'b1, cbc_pkg::KIND_RETRY,
			cbc_pkg::TIME_MAX, 1'b0, 2'd0, 1'b0, 4'd0, 32'd0, 8'd0));

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_tab[i])
			send_event(dir_tab[i].md, dir_tab[i].sl, dir_tab[i].fk, dir_tab[i].tn,
				dir_tab[i].known, dir_tab[i].res);
		drain();

		tnow = 48'd0;
		for (int p = 0; p < PHASES; p++) begin
			write_reg(cbc_pkg::CFG_WINDOW, win_list[p]);
			write_reg(cbc_pkg::CFG_THRESH, {24'd0, thr_list[p]});
			idle_pct = pct_list[p];
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				pick = $urandom_range(99);
				if (pick < 30) md = cbc_pkg::MODE_ADMIT;
				else if (pick < 50) md = cbc_pkg::MODE_SUCCESS;
				else if (pick < 90) md = cbc_pkg::MODE_FAILURE;
				else md = cbc_pkg::MODE_RESTART;
				pick = $urandom_range(99);
				if (pick < 20) fk = cbc_pkg::KIND_IGNORED;
				else if (pick < 80) fk = cbc_pkg::KIND_RETRY;
				else if (pick < 90) fk = cbc_pkg::KIND_AUTH;
				else fk = 2'd3;
				tnow = next_time(tnow);
				send_event(md, 1'($urandom_range(1)), fk, tnow, 1'b0, none);
			end
			drain();
		end

		repeat (6) @(posedge clk);
		if (err_cnt == 0)
			$display("circuit_breaker_controller_unit_tb: done, clean");
		else
			$display("circuit_breaker_controller_unit_tb: done, errors");
		$finish;
	end

endmodule
`default_nettype wire
